[rtl/ufef_pkg.sv]
// Shared types and constants for the union-find edge filter.
// Holds the channel payload structs, register indexes and sequencer states.
// No dependencies.
package ufef_pkg;

  // Fixed field widths
  localparam int CELL_W   = 10;
  localparam int WEIGHT_W = 2;
  localparam int CFG_W    = 6;
  localparam int KEPT_W   = 10;
  localparam int RANK_W   = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [KEPT_W-1:0] KEPT_MAX = 10'd1023;
  localparam logic [CFG_W-1:0]  GRID_RESET = 6'd32;

  localparam int DEF_MAX_CELLS = 1024;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_a;
    logic [CELL_W-1:0]   cell_b;
    logic [WEIGHT_W-1:0] weight;
    logic                new_maze;
    logic                last_edge;
  } ufef_in_t;

  typedef struct packed {
    logic                accepted;
    logic [CELL_W-1:0]   out_cell_a;
    logic [CELL_W-1:0]   out_cell_b;
    logic [WEIGHT_W-1:0] out_weight;
    logic [KEPT_W-1:0]   kept_count;
    logic                bad_cell;
    logic                done_res;
  } ufef_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ISSUE,
    ST_WALK,
    ST_COMPRESS,
    ST_LINK,
    ST_BUMP,
    ST_OUT
  } ufef_state_t;

endpackage

[rtl/union_find_edge_filter.sv]
// Kruskal edge filter on a union-find store (ufef_ctrl, ufef_store, ufef_pkg).
// From input transfer to out_valid: a bad cell goes straight to the result; else each end walks its
//   parent chain, a non-root start cell is pointed at its root, then any merge and an equal-rank bump.
// One edge at a time, the next taken only once the result moves to the output register; the pace
//   is set by the parent walk on the single store read port; new_maze adds a full MAX_CELLS sweep.
// Reset (sync, rst_n low): grid 32x32, count zero, full MAX_CELLS sweep with in_ready low.
module union_find_edge_filter #(
  parameter int MAX_CELLS = ufef_pkg::DEF_MAX_CELLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ufef_pkg::ufef_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ufef_pkg::ufef_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [ufef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ufef_pkg::CFG_W-1:0]        cfg_wdata
);
  import ufef_pkg::*;

  localparam int CAP_W  = $clog2(MAX_CELLS + 1);
  localparam int PROD_W = 2 * CFG_W;
  localparam int LW     = (CAP_W > PROD_W) ? CAP_W : PROD_W;

  logic [CFG_W-1:0] grid_rows_r;
  logic [CFG_W-1:0] grid_cols_r;
  logic [LW-1:0]    cell_prod;
  logic [LW-1:0]    cell_limit;

  logic             res_valid;
  logic             res_ready;
  ufef_out_t        res_data;
  logic             out_valid_r;
  ufef_out_t        out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_RESET;
      grid_cols_r <= GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        REG_GRID_COLS: grid_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Cell limit: rows * cols, capped at the store depth
  assign cell_prod  = LW'(grid_rows_r) * LW'(grid_cols_r);
  assign cell_limit = (cell_prod > LW'(MAX_CELLS)) ? LW'(MAX_CELLS) : cell_prod;

  ufef_ctrl #(
    .MAX_CELLS (MAX_CELLS),
    .LW        (LW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_limit (cell_limit),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // Output register: load a finished result, drop it on transfer
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/ufef_store.sv]
// Disjoint-set store: one word per cell holding {parent, rank}.
// One write port and one registered read port. Depends on nothing.
module ufef_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ufef_ctrl.sv]
// Sequencer of the edge filter: clearing sweep, root walks with compression,
// union by rank and the kept-edge counter. Depends on ufef_pkg and drives ufef_store.
module ufef_ctrl #(
  parameter int MAX_CELLS = 1024,
  parameter int LW        = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LW-1:0]      cell_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  ufef_pkg::ufef_in_t in_data,
  output logic               res_valid,
  input  logic               res_ready,
  output ufef_pkg::ufef_out_t res_data
);
  import ufef_pkg::*;

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int DW = AW + RANK_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_CELLS - 1);

  ufef_state_t       state_r, state_nxt;
  ufef_in_t          item_r, item_nxt;
  logic              bad_r, bad_nxt;
  logic              side_r, side_nxt;
  logic              first_r, first_nxt;
  logic              acc_r, acc_nxt;
  logic              boot_r, boot_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [RANK_W-1:0] start_rank_r, start_rank_nxt;
  logic [AW-1:0]     root_a_r, root_a_nxt;
  logic [RANK_W-1:0] rank_a_r, rank_a_nxt;
  logic [AW-1:0]     root_b_r, root_b_nxt;
  logic [RANK_W-1:0] rank_b_r, rank_b_nxt;
  logic [KEPT_W-1:0] kept_r, kept_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DW-1:0]     mem_rdata;

  logic [AW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic [AW-1:0]     start_idx;
  logic              in_bad;
  ufef_state_t       after_clear;
  ufef_state_t       after_find;

  ufef_store #(
    .DEPTH (MAX_CELLS),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_parent = mem_rdata[DW-1:RANK_W];
  assign rd_rank   = mem_rdata[RANK_W-1:0];
  assign start_idx = side_r ? AW'(item_r.cell_b) : AW'(item_r.cell_a);

  // Range check against the live grid size
  assign in_bad = (LW'(in_data.cell_a) >= cell_limit) || (LW'(in_data.cell_b) >= cell_limit);

  assign after_clear = boot_r ? ST_IDLE : (bad_r ? ST_OUT : ST_ISSUE);
  // cur_r holds the root found by the walk, both in WALK and in COMPRESS
  assign after_find  = !side_r ? ST_ISSUE : ((root_a_r == cur_r) ? ST_OUT : ST_LINK);

  // Result payload
  always_comb begin
    res_data.accepted   = acc_r;
    res_data.out_cell_a = item_r.cell_a;
    res_data.out_cell_b = item_r.cell_b;
    res_data.out_weight = item_r.weight;
    res_data.kept_count = kept_r;
    res_data.bad_cell   = bad_r;
    res_data.done_res   = item_r.last_edge;
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      boot_r  <= 1'b1;
      kept_r  <= '0;
      side_r  <= 1'b0;
      first_r <= 1'b0;
      acc_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      boot_r  <= boot_nxt;
      kept_r  <= kept_nxt;
      side_r  <= side_nxt;
      first_r <= first_nxt;
      acc_r   <= acc_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    cur_r        <= cur_nxt;
    start_rank_r <= start_rank_nxt;
    root_a_r     <= root_a_nxt;
    rank_a_r     <= rank_a_nxt;
    root_b_r     <= root_b_nxt;
    rank_b_r     <= rank_b_nxt;
  end

  // Next state and store accesses
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    bad_nxt        = bad_r;
    side_nxt       = side_r;
    first_nxt      = first_r;
    acc_nxt        = acc_r;
    boot_nxt       = boot_r;
    cur_nxt        = cur_r;
    clr_nxt        = clr_r;
    start_rank_nxt = start_rank_r;
    root_a_nxt     = root_a_r;
    rank_a_nxt     = rank_a_r;
    root_b_nxt     = root_b_r;
    rank_b_nxt     = rank_b_r;
    kept_nxt       = kept_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = {clr_r, RANK_W'(0)};
    mem_raddr      = cur_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          bad_nxt  = in_bad;
          side_nxt = 1'b0;
          acc_nxt  = 1'b0;
          if (in_data.new_maze) begin
            clr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = in_bad ? ST_OUT : ST_ISSUE;
          end
        end
      end

      // Sweep every cell back to its own set
      ST_CLEAR: begin
        mem_we   = 1'b1;
        kept_nxt = '0;
        if (clr_r == LAST_IDX) begin
          boot_nxt  = 1'b0;
          state_nxt = after_clear;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      // Start a root walk from the current end of the edge
      ST_ISSUE: begin
        mem_raddr = start_idx;
        cur_nxt   = start_idx;
        first_nxt = 1'b1;
        state_nxt = ST_WALK;
      end

      // Follow parent pointers, one hop per cycle
      ST_WALK: begin
        first_nxt = 1'b0;
        if (first_r) begin
          start_rank_nxt = rd_rank;
        end
        if (rd_parent == cur_r) begin
          if (!side_r) begin
            root_a_nxt = cur_r;
            rank_a_nxt = rd_rank;
          end else begin
            root_b_nxt = cur_r;
            rank_b_nxt = rd_rank;
          end
          if (first_r) begin
            side_nxt  = 1'b1;
            state_nxt = after_find;
          end else begin
            state_nxt = ST_COMPRESS;
          end
        end else begin
          cur_nxt   = rd_parent;
          mem_raddr = rd_parent;
        end
      end

      // Point the start cell straight at its root
      ST_COMPRESS: begin
        mem_we    = 1'b1;
        mem_waddr = start_idx;
        mem_wdata = {cur_r, start_rank_r};
        side_nxt  = 1'b1;
        state_nxt = after_find;
      end

      // Hang the lower-rank root under the other (b under a on equal ranks) and count the edge
      ST_LINK: begin
        mem_we  = 1'b1;
        acc_nxt = 1'b1;
        if (kept_r != KEPT_MAX) begin
          kept_nxt = kept_r + KEPT_W'(1);
        end
        if (rank_a_r < rank_b_r) begin
          mem_waddr = root_a_r;
          mem_wdata = {root_b_r, rank_a_r};
          state_nxt = ST_OUT;
        end else begin
          mem_waddr = root_b_r;
          mem_wdata = {root_a_r, rank_b_r};
          state_nxt = (rank_a_r == rank_b_r) ? ST_BUMP : ST_OUT;
        end
      end

      // Equal ranks: raise the surviving root's rank, saturating
      ST_BUMP: begin
        mem_we    = 1'b1;
        mem_waddr = root_a_r;
        mem_wdata = {root_a_r, (rank_a_r == RANK_MAX) ? RANK_MAX : rank_a_r + RANK_W'(1)};
        state_nxt = ST_OUT;
      end

      // Hand the result to the output register
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

endmodule

[rtl/ufef_checker.sv]
// Port-level checks for union_find_edge_filter, attached by bind.
// Depends on ufef_pkg.
module ufef_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ufef_pkg::ufef_out_t out_data
);
  import ufef_pkg::*;

  // A waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One edge at a time: busy right after an input transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an edge is in flight");

  // Reset starts the clearing sweep
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block ready during the post-reset sweep");

  // A flagged edge is never kept
  a_bad_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_cell |-> !out_data.accepted)
    else $error("edge with a bad cell reported as accepted");

  // A kept edge always shows a nonzero count
  a_kept_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.kept_count != '0)
    else $error("accepted edge with zero kept count");

endmodule

bind union_find_edge_filter ufef_checker u_ufef_checker (.*);
